### rtl/core/arpc_pkg.sv
// Shared constants, codes and control types of the address-resolution cache.
package arpc_pkg;

  localparam int unsigned CacheDepth = 64;
  localparam int unsigned SlotW      = $clog2(CacheDepth);
  localparam int unsigned CmdW       = 2;
  localparam int unsigned IpW        = 32;
  localparam int unsigned MacW       = 48;

  typedef enum logic [CmdW-1:0] {
    CmdLookup = 2'd0,
    CmdInsert = 2'd1,
    CmdDelete = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StResolve,
    StLoad
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic resolve;
    logic load;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

### rtl/core/arpc_if.sv
// Request and response channel interfaces of the address-resolution cache.
interface arpc_req_if import arpc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [IpW-1:0]  ip_address;
  logic [MacW-1:0] mac_address;

  modport source (output valid, output command, output ip_address, output mac_address,
                  input ready);
  modport sink (input valid, input command, input ip_address, input mac_address,
                output ready);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            status;
  logic [MacW-1:0] found_mac;

  modport source (output valid, output status, output found_mac, input ready);
  modport sink (input valid, input status, input found_mac, output ready);
endinterface

### rtl/core/arp_cache_round_robin_table_top.sv
// Address-resolution cache with round-robin replacement: each command passes the transfer
// edge, a resolve step and a load step before its result sits in the output register. The
// transfer edge compares the address against every entry in parallel and registers the match
// vector, the resolve step picks the lowest match, updates the table and reads the MAC memory,
// and the load step loads the output register. A new command is taken on the cycle after that
// load, so only one command is in flight at a time; a held response stalls only the load step.
// Valid marks clear at reset, with no clearing pass.
module arp_cache_round_robin_table_top import arpc_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  arpc_req_if.sink    req_i,
  arpc_rsp_if.source  rsp_o
);

  ctrl_t ctrl;
  stat_t stat;

  arpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  arpc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .command_i     (req_i.command),
    .ip_address_i  (req_i.ip_address),
    .mac_address_i (req_i.mac_address),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .status_o      (rsp_o.status),
    .found_mac_o   (rsp_o.found_mac)
  );

endmodule

### rtl/core/arpc_ctrl.sv
// Controller state machine of the address-resolution cache.
module arpc_ctrl import arpc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (req_valid_i) state_d = StResolve;
      end
      StResolve: begin
        state_d = StLoad;
      end
      StLoad: begin
        if (stat_i.out_free) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    req_ready_o    = 1'b0;
    ctrl_o         = '0;
    case (state_q)
      StIdle: begin
        req_ready_o    = 1'b1;
        ctrl_o.capture = req_valid_i;
      end
      StResolve: begin
        ctrl_o.resolve = 1'b1;
      end
      StLoad: begin
        ctrl_o.load = stat_i.out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

### rtl/core/arpc_dp.sv
// Datapath of the address-resolution cache: entry table, match lanes and output register.
module arpc_dp import arpc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_t           ctrl_i,
  output stat_t           stat_o,
  input  logic [CmdW-1:0] command_i,
  input  logic [IpW-1:0]  ip_address_i,
  input  logic [MacW-1:0] mac_address_i,
  input  logic            rsp_ready_i,
  output logic            rsp_valid_o,
  output logic            status_o,
  output logic [MacW-1:0] found_mac_o
);

  logic [IpW-1:0]        entry_ip_q [CacheDepth];
  logic [MacW-1:0]       mac_mem [CacheDepth];
  logic [CacheDepth-1:0] valid_q;
  logic [SlotW-1:0]      slot_q;
  logic [SlotW-1:0]      slot_next;

  cmd_e                  cmd_q;
  logic [IpW-1:0]        ip_q;
  logic [MacW-1:0]       mac_q;
  logic [CacheDepth-1:0] match_q, match_d;

  logic                  hit_any;
  logic [SlotW-1:0]      hit_idx;
  logic                  res_status_d, res_status_q;
  logic                  res_found_d, res_found_q;
  logic [MacW-1:0]       mac_rd_q;

  logic                  rsp_valid_q;
  logic                  status_q;
  logic [MacW-1:0]       found_mac_q;

  // Every entry compares against the incoming address in its own lane.
  always_comb begin
    for (int i = 0; i < CacheDepth; i++) begin
      match_d[i] = valid_q[i] && (entry_ip_q[i] == ip_address_i);
    end
  end

  // The lowest matching index wins.
  always_comb begin
    hit_idx = '0;
    for (int i = CacheDepth - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = SlotW'(i);
    end
  end

  assign hit_any   = |match_q;
  assign slot_next = (slot_q == SlotW'(CacheDepth - 1)) ? '0 : slot_q + 1'b1;

  always_comb begin
    res_status_d = 1'b1;
    res_found_d  = 1'b0;
    case (cmd_q)
      CmdLookup: begin
        res_status_d = !hit_any;
        res_found_d  = hit_any;
      end
      CmdInsert: begin
        res_status_d = 1'b0;
      end
      CmdDelete: begin
        res_status_d = !hit_any;
      end
      default: begin
        res_status_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      slot_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.resolve) begin
        if (cmd_q == CmdInsert) begin
          valid_q[slot_q] <= 1'b1;
          slot_q          <= slot_next;
        end else if (cmd_q == CmdDelete && hit_any) begin
          valid_q[hit_idx] <= 1'b0;
        end
      end
      if (ctrl_i.load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= cmd_e'(command_i);
      ip_q    <= ip_address_i;
      mac_q   <= mac_address_i;
      match_q <= match_d;
    end
    if (ctrl_i.resolve) begin
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
      if (cmd_q == CmdInsert) begin
        entry_ip_q[slot_q] <= ip_q;
      end
    end
    if (ctrl_i.load) begin
      status_q    <= res_status_q;
      found_mac_q <= res_found_q ? mac_rd_q : '0;
    end
  end

  // MAC memory: one write port for inserts, one registered read port for lookups.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.resolve && cmd_q == CmdInsert) begin
      mac_mem[slot_q] <= mac_q;
    end
    if (ctrl_i.resolve && cmd_q == CmdLookup) begin
      mac_rd_q <= mac_mem[hit_idx];
    end
  end

  assign stat_o.out_free = !rsp_valid_q || rsp_ready_i;
  assign rsp_valid_o     = rsp_valid_q;
  assign status_o        = status_q;
  assign found_mac_o     = found_mac_q;

endmodule

### rtl/core/arpc_chk.sv
// Port-level checker of the address-resolution cache and its bind to the top level.
module arpc_chk import arpc_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_i,
  input logic            rsp_valid_i,
  input logic            rsp_ready_i,
  input logic            rsp_status_i,
  input logic [MacW-1:0] rsp_found_mac_i
);

  // Only one command is in flight: after a transfer the request side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken while a command is in flight");

  // A fresh response never appears right after the request side was open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> !$past(req_ready_i))
    else $error("response appeared without the command pipeline");

  // A MAC is reported only together with success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_found_mac_i != '0)) |-> !rsp_status_i)
    else $error("nonzero MAC with not-found status");

  // A stalled response keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_found_mac_i) && $stable(rsp_status_i)))
    else $error("stalled response changed");

endmodule

bind arp_cache_round_robin_table_top arpc_chk u_arpc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_status_i    (rsp_o.status),
  .rsp_found_mac_i (rsp_o.found_mac)
);

### tb/arp_table_checker.sv
// Shadow model of the address-resolution table that predicts and checks every response.
`timescale 1ns / 1ps

module arp_table_checker import arpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  arpc_req_if         req_mon,
  arpc_rsp_if         rsp_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned awaited_o
);

  typedef struct packed {
    logic            status;
    logic [MacW-1:0] found_mac;
  } reply_t;

  logic [IpW-1:0]   shadow_ip    [CacheDepth];
  logic [MacW-1:0]  shadow_mac   [CacheDepth];
  logic             shadow_valid [CacheDepth];
  logic [SlotW-1:0] insert_slot;

  reply_t      expected_replies[$];
  int unsigned mismatch_cnt = 0;
  int unsigned awaited = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign awaited_o      = awaited;

  // Lowest valid entry that holds the address, or the table depth when there is none.
  function automatic int first_hit(input logic [IpW-1:0] ip);
    for (int i = 0; i < int'(CacheDepth); i++) begin
      if (shadow_valid[i] && shadow_ip[i] == ip) return i;
    end
    return int'(CacheDepth);
  endfunction

  // Applies one command to the shadow table and returns the response it must produce.
  function automatic reply_t resolve_command(input logic [CmdW-1:0] cmd,
                                             input logic [IpW-1:0]  ip,
                                             input logic [MacW-1:0] mac);
    reply_t reply;
    int     hit;
    reply.status    = 1'b1;
    reply.found_mac = '0;
    hit             = first_hit(ip);
    case (cmd)
      CmdLookup: begin
        if (hit < int'(CacheDepth)) begin
          reply.status    = 1'b0;
          reply.found_mac = shadow_mac[hit];
        end
      end
      CmdInsert: begin
        shadow_ip[insert_slot]    = ip;
        shadow_mac[insert_slot]   = mac;
        shadow_valid[insert_slot] = 1'b1;
        insert_slot  = SlotW'((int'(insert_slot) + 1) % int'(CacheDepth));
        reply.status = 1'b0;
      end
      CmdDelete: begin
        if (hit < int'(CacheDepth)) begin
          shadow_valid[hit] = 1'b0;
          reply.status      = 1'b0;
        end
      end
      default: begin
        // Unknown commands leave the table alone and report not found.
      end
    endcase
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < int'(CacheDepth); i++) shadow_valid[i] = 1'b0;
      insert_slot = '0;
      expected_replies.delete();
      awaited = 0;
    end else begin
      // The response side is handled first so that a request taken on the same edge
      // cannot cover for a spurious response.
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status    = rsp_mon.status;
        got.found_mac = rsp_mon.found_mac;
        if (expected_replies.size() == 0) begin
          $error("response transfer with none expected: status %0d, found_mac %012h",
                 got.status, got.found_mac);
          mismatch_cnt++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            mismatch_cnt++;
          end
          if (got.found_mac !== want.found_mac) begin
            $error("found_mac mismatch: expected %012h, actual %012h",
                   want.found_mac, got.found_mac);
            mismatch_cnt++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_replies.push_back(resolve_command(req_mon.command, req_mon.ip_address,
                                                   req_mon.mac_address));
      end
      awaited = expected_replies.size();
    end
  end

endmodule

### tb/tb_arp_cache_round_robin_table_top.sv
// Testbench top: drives commands into the address-resolution cache and reports the verdict.
`timescale 1ns / 1ps

module tb_arp_cache_round_robin_table_top;
  import arpc_pkg::*;

  localparam int          ClkPeriod   = 12;
  localparam int          RandomItems = 1800;
  localparam int          HoldCycles  = 400;
  localparam int          PoolSize    = 16;
  localparam int          DrainLimit  = 5000;
  localparam logic [CmdW-1:0] CmdUnknown = 2'd3;

  logic clk_i;
  logic rst_ni;

  arpc_req_if req_if ();
  arpc_rsp_if rsp_if ();

  int unsigned mismatch_cnt;
  int unsigned awaited_cnt;
  bit          src_idle_en;
  bit          rsp_idle_en;
  int unsigned hold_token;
  logic [IpW-1:0] ip_pool [PoolSize];

  arp_cache_round_robin_table_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  arp_table_checker u_table_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .rsp_mon        (rsp_if),
    .mismatch_cnt_o (mismatch_cnt),
    .awaited_o      (awaited_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("arp_cache_round_robin_table_top regression: fail");
    $finish;
  end

  // Response side: random back-pressure, plus a long hold each time the token moves.
  initial begin : rsp_ready_gen
    int unsigned hold_left;
    int unsigned hold_seen;
    bit          idle_now;
    hold_left     = 0;
    hold_seen     = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      idle_now = rsp_idle_en;
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      @(negedge clk_i);
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= !idle_now || ($urandom_range(99) >= 25);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(input logic [CmdW-1:0] cmd, input logic [IpW-1:0] ip,
                          input logic [MacW-1:0] mac);
    while (src_idle_en && $urandom_range(99) < 25) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.command     <= cmd;
    req_if.ip_address  <= ip;
    req_if.mac_address <= mac;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  function automatic logic [MacW-1:0] random_mac();
    return {16'($urandom()), $urandom()};
  endfunction

  // Most traffic reuses a small set of addresses so that lookups and deletes hit often.
  function automatic void refill_pool();
    int unsigned pick;
    for (int i = 0; i < PoolSize; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) ip_pool[i] = '0;
      else if (pick == 1) ip_pool[i] = '1;
      else ip_pool[i] = $urandom();
    end
  endfunction

  task automatic send_random_cmd();
    int unsigned    pick;
    logic [CmdW-1:0] cmd;
    logic [IpW-1:0]  ip;
    pick = $urandom_range(99);
    if (pick < 40) cmd = CmdLookup;
    else if (pick < 75) cmd = CmdInsert;
    else if (pick < 95) cmd = CmdDelete;
    else cmd = CmdUnknown;
    if ($urandom_range(99) < 80) ip = ip_pool[$urandom_range(PoolSize - 1)];
    else ip = $urandom();
    send_cmd(cmd, ip, random_mac());
  endtask

  initial begin : stimulus
    int unsigned drain_cycles;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.command     = CmdLookup;
    req_if.ip_address  = '0;
    req_if.mac_address = '0;
    src_idle_en        = 1'b1;
    rsp_idle_en        = 1'b1;
    hold_token         = 0;
    refill_pool();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty table, unknown command, and the extremes of both address fields.
    send_cmd(CmdLookup, '0, '0);
    send_cmd(CmdDelete, '1, '0);
    send_cmd(CmdUnknown, '0, '1);
    send_cmd(CmdInsert, '0, '0);
    send_cmd(CmdInsert, '1, '1);
    send_cmd(CmdLookup, '0, '0);
    send_cmd(CmdLookup, '1, '0);
    // Duplicate inserts: the lower slot wins until it is deleted.
    send_cmd(CmdInsert, 32'h0A00_0001, 48'h0000_0000_0001);
    send_cmd(CmdInsert, 32'h0A00_0001, 48'h8000_0000_0000);
    send_cmd(CmdLookup, 32'h0A00_0001, '0);
    send_cmd(CmdDelete, 32'h0A00_0001, '0);
    send_cmd(CmdLookup, 32'h0A00_0001, '0);
    send_cmd(CmdUnknown, 32'h0A00_0001, 48'h1234_5678_9ABC);
    send_cmd(CmdLookup, 32'h0A00_0001, '0);
    send_cmd(CmdDelete, 32'h0A00_0001, '0);
    send_cmd(CmdDelete, 32'h0A00_0001, '0);
    send_cmd(CmdLookup, 32'h0A00_0001, '0);
    send_cmd(CmdInsert, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
    send_cmd(CmdInsert, 32'h5555_5555, 48'h5555_5555_5555);
    send_cmd(CmdLookup, 32'hAAAA_AAAA, '1);
    send_cmd(CmdLookup, 32'h5555_5555, '0);
    send_cmd(CmdLookup, '1, '1);
    send_cmd(CmdDelete, '0, '1);

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 200 == 0) refill_pool();
      src_idle_en = !(n >= 600 && n < 900);
      rsp_idle_en = !(n >= 600 && n < 900);
      if (n == 400) hold_token++;
      if (n == 1200) begin
        // Let the block drain completely before traffic resumes.
        req_if.valid <= 1'b0;
        @(negedge clk_i);
        while (awaited_cnt != 0) @(negedge clk_i);
      end
      send_random_cmd();
    end

    req_if.valid <= 1'b0;
    drain_cycles = 0;
    while (awaited_cnt != 0 && drain_cycles < DrainLimit) begin
      @(negedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(negedge clk_i);
    if (awaited_cnt != 0) $error("%0d expected responses never arrived", awaited_cnt);

    if (mismatch_cnt == 0 && awaited_cnt == 0) begin
      $display("arp_cache_round_robin_table_top regression: pass");
    end else begin
      $display("arp_cache_round_robin_table_top regression: fail");
    end
    $finish;
  end

endmodule
